### rtl/rcb_pkg.sv
package rcb_pkg;

  localparam int WORD_W    = 64;
  localparam int SEQ_W     = 64;
  localparam int BIT_W     = 6;
  localparam int BASE_W    = 58;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int MOD_CNT_W = 6;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PREFIX = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BELOW  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic look;
    logic rmw;
    logic casc_rd;
    logic casc_chk;
    logic mod_step;
    logic mod_fin;
    logic load_out;
  } rcb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
    logic is_prefix;
    logic collapse;
    logic casc_more;
    logic mod_last;
  } rcb_sts_t;

endpackage

### rtl/rcb_datapath.sv
module rcb_datapath #(
  parameter int RING_WORDS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rcb_pkg::KIND_W-1:0]    kind_i,
  input  logic [rcb_pkg::SEQ_W-1:0]     seq_value_i,
  input  rcb_pkg::rcb_cmd_t             cmd_i,
  output rcb_pkg::rcb_sts_t             sts_o,
  output logic [rcb_pkg::STATUS_W-1:0]  status_o,
  output logic                          found_o,
  output logic [rcb_pkg::BASE_W-1:0]    base_words_o
);
  import rcb_pkg::*;

  localparam int                SLOT_W    = $clog2(RING_WORDS);
  localparam logic [BASE_W-1:0] RING_BASE = BASE_W'(RING_WORDS);
  localparam logic [SLOT_W:0]   RING_EXT  = (SLOT_W + 1)'(RING_WORDS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_WORDS - 1);

  // Remainder unit: fold 8-bit chunks, then reduce by reciprocal multiply
  localparam int     CHUNK_W    = 8;
  localparam int     NUM_CHUNKS = (BASE_W + CHUNK_W - 1) / CHUNK_W;
  localparam int     CHUNK_IX_W = $clog2(NUM_CHUNKS);
  localparam int     ACC_W      = CHUNK_W + SLOT_W + CHUNK_IX_W;
  localparam int     QUO_W      = ACC_W - SLOT_W + 1;
  localparam int     RECIP_SH   = ACC_W + SLOT_W;
  localparam longint RECIP      = ((longint'(1) << RECIP_SH) + longint'(RING_WORDS) -
                                   longint'(1)) / longint'(RING_WORDS);
  localparam logic [ACC_W:0]   RECIP_M  = (ACC_W + 1)'(RECIP);
  localparam logic [ACC_W-1:0] RING_ACC = ACC_W'(RING_WORDS);

  logic [KIND_W-1:0]    kind_q;
  logic [BASE_W-1:0]    word_q;
  logic [BIT_W-1:0]     bit_q;
  logic [BASE_W-1:0]    base_q;
  logic [SLOT_W-1:0]    base_slot_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 below_q;
  logic                 beyond_q;
  logic                 head_q;
  logic [STATUS_W-1:0]  pend_status_q;
  logic                 pend_found_q;
  logic [WORD_W-1:0]    mem_q [RING_WORDS];
  logic [WORD_W-1:0]    rdata_q;
  logic [SLOT_W-1:0]    clr_idx_q;
  logic [BASE_W-1:0]    mod_sh_q;
  logic [ACC_W-1:0]     acc_q;
  logic [QUO_W-1:0]     quo_q;
  logic [SLOT_W-1:0]    rem_q;
  logic [MOD_CNT_W-1:0] mod_cnt_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic                 out_found_q;
  logic [BASE_W-1:0]    out_base_q;

  logic [BASE_W-1:0]   diff;
  logic                below;
  logic                beyond;
  logic [SLOT_W:0]     slot_sum;
  logic [SLOT_W:0]     slot_wrap;
  logic [SLOT_W-1:0]   look_slot;
  logic [STATUS_W-1:0] look_status;
  logic [WORD_W-1:0]   ins_word;
  logic [WORD_W-1:0]   prefix_mask;
  logic                in_win;
  logic                is_ins;
  logic                is_qry;
  logic                base_max;
  logic                collapse;
  logic                casc_more;
  logic                found_now;
  logic [SLOT_W-1:0]   weight_tab [NUM_CHUNKS];
  logic [ACC_W-1:0]    chunk_term;
  logic [2*ACC_W:0]    recip_prod;
  logic [ACC_W-1:0]    rem_full;
  logic [SLOT_W-1:0]   slot_adv;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;

  // Place value of chunk idx, mod RING_WORDS
  function automatic int chunk_weight(int idx);
    int w;
    w = 1 % RING_WORDS;
    for (int i = 0; i < idx * CHUNK_W; i++) begin
      w = (w * 2) % RING_WORDS;
    end
    return w;
  endfunction

  for (genvar g = 0; g < NUM_CHUNKS; g++) begin : g_weight
    assign weight_tab[g] = SLOT_W'(chunk_weight(g));
  end

  always_comb begin
    diff      = word_q - base_q;
    below     = word_q < base_q;
    beyond    = !below && (diff >= RING_BASE);
    slot_sum  = {1'b0, base_slot_q} + {1'b0, diff[SLOT_W-1:0]};
    slot_wrap = (slot_sum >= RING_EXT) ? slot_sum - RING_EXT : slot_sum;
    look_slot = (below || beyond) ? '0 : slot_wrap[SLOT_W-1:0];

    is_ins = kind_q == KIND_INSERT;
    is_qry = kind_q == KIND_QUERY;

    if (is_ins && below) begin
      look_status = STATUS_BELOW;
    end else if (is_ins && beyond) begin
      look_status = STATUS_BEYOND;
    end else begin
      look_status = STATUS_OK;
    end

    in_win      = !below_q && !beyond_q;
    base_max    = &base_q;
    ins_word    = rdata_q | (WORD_W'(1) << bit_q);
    prefix_mask = (WORD_W'(1) << bit_q) - WORD_W'(1);
    collapse    = is_ins && in_win && (&ins_word) && head_q && !base_max;
    casc_more   = (&rdata_q) && !base_max;
    found_now   = is_qry && (below_q || (!beyond_q && rdata_q[bit_q]));

    // Fold one chunk per step, then quotient, then remainder
    chunk_term = ACC_W'(mod_sh_q[CHUNK_W-1:0]) *
                 ACC_W'(weight_tab[mod_cnt_q[CHUNK_IX_W-1:0]]);
    recip_prod = (2*ACC_W+1)'(acc_q) * (2*ACC_W+1)'(RECIP_M);
    rem_full   = acc_q - ACC_W'(quo_q) * RING_ACC;

    slot_adv = (base_slot_q == LAST_SLOT) ? '0 : base_slot_q + SLOT_W'(1);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx_q;
    wr_data = '0;
    priority if (cmd_i.clear_en) begin
      wr_en = 1'b1;
    end else if (cmd_i.rmw && is_ins && in_win) begin
      wr_en   = 1'b1;
      wr_addr = slot_q;
      wr_data = collapse ? '0 : ins_word;
    end else if (cmd_i.casc_chk && casc_more) begin
      wr_en   = 1'b1;
      wr_addr = base_slot_q;
    end else if (cmd_i.mod_fin && (bit_q != '0)) begin
      wr_en   = 1'b1;
      wr_addr = rem_q;
      wr_data = prefix_mask;
    end
    rd_en   = cmd_i.look || cmd_i.casc_rd;
    rd_addr = cmd_i.look ? look_slot : base_slot_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      base_slot_q <= '0;
      clr_idx_q   <= '0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_idx_q <= clr_idx_q + SLOT_W'(1);
      end
      if (cmd_i.look && (kind_q == KIND_PREFIX)) begin
        base_q <= word_q;
      end
      if ((cmd_i.rmw && collapse) || (cmd_i.casc_chk && casc_more)) begin
        base_q      <= base_q + BASE_W'(1);
        base_slot_q <= slot_adv;
      end
      if (cmd_i.mod_fin) begin
        base_slot_q <= rem_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      word_q <= seq_value_i[SEQ_W-1:BIT_W];
      bit_q  <= seq_value_i[BIT_W-1:0];
    end
    if (cmd_i.look) begin
      slot_q        <= look_slot;
      below_q       <= below;
      beyond_q      <= beyond;
      head_q        <= word_q == base_q;
      pend_status_q <= look_status;
      pend_found_q  <= 1'b0;
      mod_sh_q      <= word_q;
      acc_q         <= '0;
      mod_cnt_q     <= '0;
    end
    if (cmd_i.mod_step) begin
      mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
      if (mod_cnt_q < MOD_CNT_W'(NUM_CHUNKS)) begin
        acc_q    <= acc_q + chunk_term;
        mod_sh_q <= mod_sh_q >> CHUNK_W;
      end else if (mod_cnt_q == MOD_CNT_W'(NUM_CHUNKS)) begin
        quo_q <= recip_prod[2*ACC_W:RECIP_SH];
      end else begin
        rem_q <= rem_full[SLOT_W-1:0];
      end
    end
    if (cmd_i.rmw) begin
      pend_found_q <= found_now;
    end
    if (cmd_i.load_out) begin
      out_status_q <= pend_status_q;
      out_found_q  <= cmd_i.rmw ? found_now : pend_found_q;
      out_base_q   <= base_q;
    end
  end

  assign sts_o.clear_last = clr_idx_q == LAST_SLOT;
  assign sts_o.is_prefix  = kind_q == KIND_PREFIX;
  assign sts_o.collapse   = collapse;
  assign sts_o.casc_more  = casc_more;
  assign sts_o.mod_last   = mod_cnt_q == MOD_CNT_W'(NUM_CHUNKS + 1);

  assign status_o     = out_status_q;
  assign found_o      = out_found_q;
  assign base_words_o = out_base_q;

endmodule

### rtl/rcb_controller.sv
module rcb_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rcb_pkg::rcb_sts_t sts_i,
  output rcb_pkg::rcb_cmd_t cmd_o
);
  import rcb_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_RMW,
    S_CRD,
    S_CCHK,
    S_MOD,
    S_MFIN,
    S_DONE
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  rcb_cmd_t cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        state_d  = sts_i.is_prefix ? S_MOD : S_RMW;
      end
      S_RMW: begin
        cmd.rmw = 1'b1;
        if (sts_i.collapse) begin
          state_d = S_CRD;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CRD: begin
        cmd.casc_rd = 1'b1;
        state_d     = S_CCHK;
      end
      S_CCHK: begin
        cmd.casc_chk = 1'b1;
        if (sts_i.casc_more) begin
          state_d = S_CRD;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_MFIN;
        end
      end
      S_MFIN: begin
        cmd.mod_fin = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o)
    else $error("input ready during clearing pass");

  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_LOOK)
    else $error("accepted transaction did not enter lookup");

  a_mfin_after_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MFIN |-> $past(state_q) == S_MOD)
    else $error("prefix finish without remainder pass");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_q)
    else $error("result loaded but not presented");

endmodule

### rtl/rolling_completion_bitmap.sv
// Rolling completion bitmap: records which 64-bit sequence numbers are done.
// Input channel (in_valid_i/in_ready_o): kind_i and seq_value_i. Kind insert
// sets the bit of seq_value_i, query reports it on found_o, mark prefix
// declares everything below seq_value_i done. Every transaction yields one
// result on the output channel (out_valid_o/out_ready_i): status_o, found_o
// and base_words_o, the count of fully completed 64-bit words afterwards.
// One transaction is worked at a time. Insert and query: the transaction is
// captured, looked up and read-modified-written, and the result is loaded
// into the output register; each full word that an insert collapses adds
// a ring read and a check. Mark prefix: captured, looked up, then the
// base-mod-RING_WORDS unit runs (eight 8-bit chunks folded one per cycle,
// then a reciprocal multiply and a subtract) before the result is loaded.
// The window ring is one memory of RING_WORDS words with a single registered
// read port.
// After reset the ring is cleared one word per cycle; in_ready_o stays low
// during that pass. A result that waits on a stalled receiver is held in the
// output register; the next transaction is still accepted and worked, and
// its result waits until the register frees up.
module rolling_completion_bitmap #(
  parameter int RING_WORDS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rcb_pkg::KIND_W-1:0]    kind_i,
  input  logic [rcb_pkg::SEQ_W-1:0]     seq_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rcb_pkg::STATUS_W-1:0]  status_o,
  output logic                          found_o,
  output logic [rcb_pkg::BASE_W-1:0]    base_words_o
);
  import rcb_pkg::*;

  rcb_cmd_t cmd;
  rcb_sts_t sts;

  // Sequencer: clearing pass, lookup, read-modify-write, cascade, prefix
  rcb_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Ring memory, base counter, window compare and remainder unit
  rcb_datapath #(
    .RING_WORDS (RING_WORDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .seq_value_i  (seq_value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .status_o     (status_o),
    .found_o      (found_o),
    .base_words_o (base_words_o)
  );

endmodule
